/* rtl/fha_pkg.sv */
// Shared types, constants, sine and clamp functions of the harmonic analysis unit.
package fha_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TBL_W    = 16;
    localparam int COEF_W   = 18;
    localparam int HIDX_W   = 5;
    localparam int QUOT_W   = 18;
    localparam int PROD_W   = 32;

    localparam logic [1:0] DIV_STEP = 2'd0;
    localparam logic [1:0] DIV_MEAN = 2'd1;
    localparam logic [1:0] DIV_COS  = 2'd2;
    localparam logic [1:0] DIV_SIN  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       div_take;
        logic [1:0] div_sel;
        logic       step_clr;
        logic       step_adv;
        logic       acc_clr;
        logic       rd_issue;
        logic       out_load;
        logic       period_end;
    } fha_cmd_t;

    typedef struct packed {
        logic rd_done;
        logic pipe_busy;
        logic div_busy;
        logic harm_zero;
        logic harm_last;
        logic out_free;
    } fha_status_t;

    function automatic logic signed [TBL_W-1:0] sine_entry(input longint u);
        longint q, r, z, z2, t, s;
        q = (u >> 14) & 3;
        r = u & 16383;
        if ((q & 1) != 0) begin
            r = 16384 - r;
        end
        z  = r * 2;
        z2 = (z * z) >> 15;
        t  = 21167 - ((z2 * 2611) >> 15);
        t  = 51472 - ((z2 * t) >> 15);
        s  = (z * t) >> 15;
        if (s > 32767) begin
            s = 32767;
        end
        if (q >= 2) begin
            s = -s;
        end
        return TBL_W'(s);
    endfunction

    function automatic logic signed [COEF_W-1:0] sat_coef(input logic [QUOT_W-1:0] q,
                                                          input logic ovf,
                                                          input logic neg);
        logic signed [COEF_W-1:0] v;
        if (!neg) begin
            if (ovf || q > QUOT_W'(131071)) begin
                v = COEF_W'(131071);
            end else begin
                v = COEF_W'(q);
            end
        end else begin
            if (ovf || q > QUOT_W'(131072)) begin
                v = -COEF_W'(131072);
            end else begin
                v = -COEF_W'(q);
            end
        end
        return v;
    endfunction

endpackage

/* rtl/fourier_harmonic_analysis_unit.sv */
// Top level of the Fourier harmonic analysis unit.
//
//  channel  dir  beat contents
//  s_       in   tdata[15:0] sample_value, tlast last_sample
//  m_       out  tdata[4:0] harmonic_index, [22:5] cos_coefficient,
//                [40:23] sin_coefficient, tlast last_result
//  cfg_     in   cfg_data[4:0] harmonic_count
//
// Samples load back to back into the store. After the last sample the table size is
// divided by N. Each harmonic then accumulates N samples, one sample per cycle through
// the store read port, then runs one division for harmonic 0 and two (cosine, then
// sine) for the others, and then hands off its result.
// Reset clears control state only; no clearing pass. A stalled result holds in the
// output register and holds the sequencer; input is refused while a period is analysed.
module fourier_harmonic_analysis_unit
    import fha_pkg::*;
#(
    parameter int MAX_SAMPLES     = 1024,
    parameter int MAX_HARMONICS   = 32,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // harmonic_index, cos_coefficient, sin_coefficient
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    fha_cmd_t    cmd;
    fha_status_t status;

    assign cfg_ready = 1'b1;

    fha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fha_datapath #(
        .MAX_SAMPLES     (MAX_SAMPLES),
        .MAX_HARMONICS   (MAX_HARMONICS),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .sample_in (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_value (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/fha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fha_div.sv */
// Restoring divider, one quotient bit per cycle, with overflow flag and remainder.
module fha_div #(
    parameter int DW = 48,
    parameter int VW = 11,
    parameter int QW = 18
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [QW-1:0] quot,
    output logic [VW-1:0] rem,
    output logic          ovf
);

    localparam int CNTW = $clog2(QW + 1);

    logic [VW-1:0]   rem_reg;
    logic [QW-1:0]   low_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            ovf_reg;
    logic [VW:0]     r2;
    logic            qbit;
    logic [VW:0]     r2_sub;

    always_comb begin
        r2     = {rem_reg, low_reg[QW-1]};
        qbit   = (r2 >= {1'b0, divisor});
        r2_sub = r2 - {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNTW'(QW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ovf_reg <= (dividend[DW-1:QW] >= (DW-QW)'(divisor));
            rem_reg <= dividend[QW+VW-1:QW];
            low_reg <= dividend[QW-1:0];
        end else if (cnt_reg != '0) begin
            rem_reg <= qbit ? r2_sub[VW-1:0] : r2[VW-1:0];
            low_reg <= {low_reg[QW-2:0], qbit};
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = low_reg;
    assign rem  = rem_reg;
    assign ovf  = ovf_reg;

endmodule

/* rtl/fha_datapath.sv */
// Sample store, phase tracking, multiply-accumulate, division and result register.
module fha_datapath
    import fha_pkg::*;
#(
    parameter int MAX_SAMPLES     = 1024,
    parameter int MAX_HARMONICS   = 32,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fha_cmd_t             cmd,
    output fha_status_t          status,
    input  logic [SAMPLE_W-1:0]  sample_in,
    input  logic                 cfg_we,
    input  logic [HIDX_W-1:0]    cfg_value,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [47:0]          m_tdata,
    output logic                 m_tlast
);

    localparam int AI      = $clog2(MAX_SAMPLES);
    localparam int CW      = $clog2(MAX_SAMPLES + 1);
    localparam int PW      = $clog2(SINE_TABLE_SIZE);
    localparam int AW      = PROD_W + CW;
    localparam int DW      = AW + 2;
    localparam int QUARTER = SINE_TABLE_SIZE / 4;
    localparam int HMAX    = MAX_HARMONICS - 1;

    logic signed [TBL_W-1:0] rom [SINE_TABLE_SIZE];

    for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_rom
        localparam longint TURN_POS = (longint'(k) * 65536) / SINE_TABLE_SIZE;
        assign rom[k] = sine_entry(TURN_POS);
    end

    logic [CW-1:0]              count_reg;
    logic [AI-1:0]              i_reg;
    logic [PW-1:0]              ph_reg;
    logic [CW-1:0]              pr_reg;
    logic [PW-1:0]              stq_reg;
    logic [CW-1:0]              str_reg;
    logic [PW-1:0]              tq_reg;
    logic [CW-1:0]              tr_reg;
    logic [HIDX_W-1:0]          n_reg;
    logic [HIDX_W-1:0]          hcnt_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       mean1_reg;
    logic signed [TBL_W-1:0]    sin_q_reg;
    logic signed [TBL_W-1:0]    cos_q_reg;
    logic signed [PROD_W-1:0]   pc_reg;
    logic signed [PROD_W-1:0]   ps_reg;
    logic signed [AW-1:0]       cacc_reg;
    logic signed [AW-1:0]       sacc_reg;
    logic signed [COEF_W-1:0]   cres_reg;
    logic signed [COEF_W-1:0]   sres_reg;
    logic                       out_valid_reg;
    logic [47:0]                out_data_reg;
    logic                       out_last_reg;

    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [PROD_W-1:0]   mul_c;
    logic signed [PROD_W-1:0]   mul_s;
    logic                       ram_we;
    logic [HIDX_W-1:0]          h_eff;
    logic [CW:0]                pr_sum;
    logic                       pr_wrap;
    logic [CW:0]                sr_sum;
    logic                       sr_wrap;
    logic [PW-1:0]              cos_addr;
    logic                       div_busy;
    logic [QUOT_W-1:0]          div_quot;
    logic [CW-1:0]              div_rem;
    logic                       div_ovf;
    logic [DW-1:0]              dividend;
    logic [AW-1:0]              cmag;
    logic [AW-1:0]              smag;
    logic                       out_free;

    assign ram_we = cmd.load && (count_reg < CW'(MAX_SAMPLES));
    assign x      = signed'(ram_rdata);
    assign mul_c  = x * cos_q_reg;
    assign mul_s  = x * sin_q_reg;

    fha_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AI-1:0]),
        .wdata (sample_in),
        .raddr (i_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        h_eff    = (int'(hcnt_reg) > HMAX) ? HIDX_W'(HMAX) : hcnt_reg;
        pr_sum   = {1'b0, pr_reg} + {1'b0, str_reg};
        pr_wrap  = (pr_sum >= {1'b0, count_reg});
        sr_sum   = {1'b0, str_reg} + {1'b0, tr_reg};
        sr_wrap  = (sr_sum >= {1'b0, count_reg});
        cos_addr = ph_reg + PW'(QUARTER);
        cmag     = cacc_reg[AW-1] ? AW'(-cacc_reg) : AW'(cacc_reg);
        smag     = sacc_reg[AW-1] ? AW'(-sacc_reg) : AW'(sacc_reg);
        case (cmd.div_sel)
            DIV_STEP: dividend = DW'(SINE_TABLE_SIZE);
            DIV_MEAN: dividend = DW'(cmag) + DW'(count_reg >> 1);
            DIV_COS:  dividend = (({1'b0, cmag, 1'b0}) + (DW'(count_reg) << 14)) >> 15;
            DIV_SIN:  dividend = (({1'b0, smag, 1'b0}) + (DW'(count_reg) << 14)) >> 15;
            default:  dividend = '0;
        endcase
    end

    fha_div #(
        .DW (DW),
        .VW (CW),
        .QW (QUOT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem),
        .ovf      (div_ovf)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            hcnt_reg  <= HIDX_W'(16);
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            if (cmd.period_end) begin
                count_reg <= '0;
            end else if (ram_we) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cfg_we) begin
                hcnt_reg <= cfg_value;
            end
            v1_reg <= cmd.rd_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            i_reg    <= '0;
            ph_reg   <= '0;
            pr_reg   <= '0;
            cacc_reg <= '0;
            sacc_reg <= '0;
        end else begin
            if (cmd.rd_issue) begin
                i_reg  <= i_reg + AI'(1);
                ph_reg <= ph_reg + stq_reg + PW'(pr_wrap);
                pr_reg <= pr_wrap ? CW'(pr_sum - {1'b0, count_reg}) : pr_sum[CW-1:0];
            end
            if (v2_reg) begin
                cacc_reg <= cacc_reg + AW'(pc_reg);
                sacc_reg <= sacc_reg + AW'(ps_reg);
            end
        end
        if (cmd.rd_issue) begin
            sin_q_reg <= rom[ph_reg];
            cos_q_reg <= rom[cos_addr];
            mean1_reg <= (n_reg == '0);
        end
        if (v1_reg) begin
            pc_reg <= mean1_reg ? PROD_W'(x) : mul_c;
            ps_reg <= mean1_reg ? '0 : mul_s;
        end
        if (cmd.step_clr) begin
            stq_reg <= '0;
            str_reg <= '0;
            n_reg   <= '0;
        end else if (cmd.step_adv) begin
            stq_reg <= stq_reg + tq_reg + PW'(sr_wrap);
            str_reg <= sr_wrap ? CW'(sr_sum - {1'b0, count_reg}) : sr_sum[CW-1:0];
            n_reg   <= n_reg + HIDX_W'(1);
        end
        if (cmd.div_take) begin
            case (cmd.div_sel)
                DIV_STEP: begin
                    tq_reg <= div_quot[PW-1:0];
                    tr_reg <= div_rem;
                end
                DIV_MEAN: begin
                    cres_reg <= sat_coef(div_quot, div_ovf, cacc_reg[AW-1]);
                    sres_reg <= '0;
                end
                DIV_COS:  cres_reg <= sat_coef(div_quot, div_ovf, cacc_reg[AW-1]);
                DIV_SIN:  sres_reg <= sat_coef(div_quot, div_ovf, sacc_reg[AW-1]);
                default:  cres_reg <= cres_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {7'b0, sres_reg, cres_reg, n_reg};
            out_last_reg <= (n_reg == h_eff);
        end
    end

    always_comb begin
        status.rd_done   = ({1'b0, i_reg} + (AI+1)'(1)) == (AI+1)'(count_reg);
        status.pipe_busy = v1_reg || v2_reg;
        status.div_busy  = div_busy;
        status.harm_zero = (n_reg == '0);
        status.harm_last = (n_reg == h_eff);
        status.out_free  = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/fha_ctrl.sv */
// Sequencer for loading, per-harmonic accumulation, division and result hand-off.
module fha_ctrl
    import fha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  fha_status_t status,
    output fha_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TDIV  = 4'd1;
    localparam logic [3:0] ST_TWAIT = 4'd2;
    localparam logic [3:0] ST_MAC   = 4'd3;
    localparam logic [3:0] ST_DRAIN = 4'd4;
    localparam logic [3:0] ST_CWAIT = 4'd5;
    localparam logic [3:0] ST_SWAIT = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;
    localparam logic [3:0] ST_SDIV  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV: begin
                cmd.div_sel   = DIV_STEP;
                cmd.div_start = 1'b1;
                state_next    = ST_TWAIT;
            end
            ST_TWAIT: begin
                cmd.div_sel = DIV_STEP;
                if (!status.div_busy) begin
                    cmd.div_take = 1'b1;
                    cmd.step_clr = 1'b1;
                    cmd.acc_clr  = 1'b1;
                    state_next   = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.rd_issue = 1'b1;
                if (status.rd_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    cmd.div_sel   = status.harm_zero ? DIV_MEAN : DIV_COS;
                    cmd.div_start = 1'b1;
                    state_next    = ST_CWAIT;
                end
            end
            ST_CWAIT: begin
                cmd.div_sel = status.harm_zero ? DIV_MEAN : DIV_COS;
                if (!status.div_busy) begin
                    cmd.div_take = 1'b1;
                    if (status.harm_zero) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SDIV;
                    end
                end
            end
            ST_SDIV: begin
                cmd.div_sel   = DIV_SIN;
                cmd.div_start = 1'b1;
                state_next    = ST_SWAIT;
            end
            ST_SWAIT: begin
                cmd.div_sel = DIV_SIN;
                if (!status.div_busy) begin
                    cmd.div_take = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.harm_last) begin
                        cmd.period_end = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.step_adv = 1'b1;
                        cmd.acc_clr  = 1'b1;
                        state_next   = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
